FILE: sv/stream_substring_match_with_context_defines.svh
// Assertion macros for the streaming substring match block.
// Included by the top level, which checks its own logic; needs clk and arst_n in scope.
`ifndef STREAM_SUBSTRING_MATCH_WITH_CONTEXT_DEFINES_SVH
`define STREAM_SUBSTRING_MATCH_WITH_CONTEXT_DEFINES_SVH
`ifndef NO_ASSERTIONS
`define SSMC_ASSERT_SAME(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("assertion failed");
`define SSMC_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("assertion failed");
`else
`define SSMC_ASSERT_SAME(label, ante, cons)
`define SSMC_ASSERT_NEXT(label, ante, cons)
`endif
`endif

FILE: sv/ssmc_pkg.sv
// Shared constants, types and register codes of the streaming substring match block.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package ssmc_pkg;
	localparam int PREFIX_MAX    = 8;
	localparam int SUFFIX_MAX    = 8;
	localparam int PATTERN_MAX   = 16;
	localparam int POSITION_BITS = 32;
	localparam int WINDOW_LEN    = PREFIX_MAX + PATTERN_MAX + SUFFIX_MAX;
	localparam int LEN_W         = $clog2(PATTERN_MAX + 1);
	localparam int DIST_W        = $clog2(SUFFIX_MAX + 1);
	localparam int OFS_W         = $clog2(WINDOW_LEN);
	localparam int PLEN_W        = $clog2(PREFIX_MAX + 1);

	typedef logic [7:0] byte_t;

	typedef enum logic [1:0] {
		REG_PATTERN_LENGTH = 2'd0,
		REG_PATTERN_LOW    = 2'd1,
		REG_PATTERN_HIGH   = 2'd2
	} reg_index_t;

	typedef struct packed {
		logic shift;
		logic clear;
	} cell_ctrl_t;

	typedef struct packed {
		logic [31:0] match_position;
		logic [3:0]  prefix_length;
		logic [63:0] prefix_context;
		logic [3:0]  suffix_length;
		logic [63:0] suffix_context;
		logic        last_of_run;
	} report_t;
endpackage
`default_nettype wire

FILE: sv/ssmc_byte_if.sv
// Input channel of the block: one stream byte and its end marker per transfer.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
interface ssmc_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       end_of_stream;

	modport source (output valid, output data_byte, output end_of_stream, input ready);
	modport sink (input valid, input data_byte, input end_of_stream, output ready);
endinterface
`default_nettype wire

FILE: sv/ssmc_report_if.sv
// Output channel of the block: one match report per transfer.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
interface ssmc_report_if;
	logic        valid;
	logic        ready;
	logic [31:0] match_position;
	logic [3:0]  prefix_length;
	logic [63:0] prefix_context;
	logic [3:0]  suffix_length;
	logic [63:0] suffix_context;
	logic        last_of_run;

	modport source (output valid, output match_position, output prefix_length,
		output prefix_context, output suffix_length, output suffix_context,
		output last_of_run, input ready);
	modport sink (input valid, input match_position, input prefix_length,
		input prefix_context, input suffix_length, input suffix_context,
		input last_of_run, output ready);
endinterface
`default_nettype wire

FILE: sv/ssmc_cell.sv
// One cell of the history window: a byte and its valid bit, loaded from its neighbor or cleared.
// Depends on ssmc_pkg.
`timescale 1ns / 1ps
`default_nettype none
module ssmc_cell (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire ssmc_pkg::cell_ctrl_t ctrl,
	input  wire ssmc_pkg::byte_t     feed_byte,
	input  wire logic                feed_valid,
	output ssmc_pkg::byte_t          data_q,
	output logic                     valid_q
);
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			data_q  <= '0;
			valid_q <= 1'b0;
		end else if (ctrl.shift) begin
			data_q  <= feed_byte;
			valid_q <= feed_valid;
		end else if (ctrl.clear) begin
			data_q  <= '0;
			valid_q <= 1'b0;
		end
	end
endmodule
`default_nettype wire

FILE: sv/ssmc_lane.sv
// Comparator lane: tests the reversed pattern against one window offset.
// Depends on ssmc_pkg.
`timescale 1ns / 1ps
`default_nettype none
module ssmc_lane (
	input  wire logic [ssmc_pkg::PATTERN_MAX-1:0][7:0] win,
	input  wire logic [ssmc_pkg::PATTERN_MAX-1:0]      win_valid,
	input  wire logic [ssmc_pkg::PATTERN_MAX-1:0][7:0] rpat,
	input  wire logic [ssmc_pkg::LEN_W-1:0]            len,
	output logic                                       hit
);
	localparam int IDX_W = $clog2(ssmc_pkg::PATTERN_MAX);
	logic [ssmc_pkg::PATTERN_MAX-1:0] agree;

	always_comb begin
		for (int j = 0; j < ssmc_pkg::PATTERN_MAX; j++) begin
			agree[j] = (win[j] == rpat[j]) || (ssmc_pkg::LEN_W'(j) >= len);
		end
		hit = win_valid[IDX_W'(len - ssmc_pkg::LEN_W'(1))] && (&agree);
	end
endmodule
`default_nettype wire

FILE: sv/ssmc_report.sv
// Builds one report from the window for the chosen suffix distance.
// Depends on ssmc_pkg.
`timescale 1ns / 1ps
`default_nettype none
module ssmc_report (
	input  wire logic [ssmc_pkg::WINDOW_LEN-1:0][7:0]  win,
	input  wire logic [ssmc_pkg::WINDOW_LEN-1:0]       win_valid,
	input  wire logic [ssmc_pkg::LEN_W-1:0]            len,
	input  wire logic [ssmc_pkg::DIST_W-1:0]           sel_dist,
	input  wire logic [ssmc_pkg::POSITION_BITS-1:0]    count,
	input  wire logic                                  last,
	output ssmc_pkg::report_t                          rpt
);
	logic [ssmc_pkg::OFS_W-1:0]              ofs;
	logic [ssmc_pkg::PREFIX_MAX-1:0]         pre_valid;
	logic [ssmc_pkg::POSITION_BITS-1:0]      pos;
	logic [ssmc_pkg::PREFIX_MAX-1:0][7:0]    pre;
	logic [ssmc_pkg::SUFFIX_MAX-1:0][7:0]    suf;

	always_comb begin
		ofs = ssmc_pkg::OFS_W'(sel_dist) + ssmc_pkg::OFS_W'(len);
		for (int k = 0; k < ssmc_pkg::PREFIX_MAX; k++) begin
			pre[k]       = win[ssmc_pkg::OFS_W'(ofs + ssmc_pkg::OFS_W'(k))];
			pre_valid[k] = win_valid[ssmc_pkg::OFS_W'(ofs + ssmc_pkg::OFS_W'(k))];
		end
		for (int k = 0; k < ssmc_pkg::SUFFIX_MAX; k++) begin
			if (ssmc_pkg::DIST_W'(k) < sel_dist) begin
				suf[k] = win[ssmc_pkg::OFS_W'(sel_dist - ssmc_pkg::DIST_W'(k)
					- ssmc_pkg::DIST_W'(1))];
			end else begin
				suf[k] = '0;
			end
		end
		pos = count - ssmc_pkg::POSITION_BITS'(sel_dist) - ssmc_pkg::POSITION_BITS'(len);
		rpt.match_position = 32'(pos);
		rpt.prefix_length  = 4'($countones(pre_valid));
		rpt.prefix_context = 64'(pre);
		rpt.suffix_length  = 4'(sel_dist);
		rpt.suffix_context = 64'(suf);
		rpt.last_of_run    = last;
	end
endmodule
`default_nettype wire

FILE: sv/stream_substring_match_with_context.sv
// Top level of the streaming substring match block with match context.
// Depends on ssmc_pkg, ssmc_byte_if, ssmc_report_if, ssmc_cell, ssmc_lane, ssmc_report
// and the assertion macro header.
//
// Channel   Role    Payload
// stream    sink    data_byte, end_of_stream
// report    source  match position, prefix and suffix context, last_of_run
// cfg_*     write   pattern length and pattern bytes, no read-back
//
// A byte enters the window cells on the transfer edge; its reports enter the single output
// register one per cycle while that register is free. A byte that causes at most one report
// lets the next byte in during the same cycle in which its report, if any, enters the output
// register. An end-of-stream byte can cause up to nine reports and holds the input until the
// last of them enters the output register, which stalls while it is full.
// Reset clears the window, counter and output valid flag; no clearing pass is needed.
`timescale 1ns / 1ps
`default_nettype none
`include "stream_substring_match_with_context_defines.svh"
module stream_substring_match_with_context (
	input  wire logic         clk,
	input  wire logic         arst_n,
	ssmc_byte_if.sink         stream,
	ssmc_report_if.source     report,
	input  wire logic         cfg_we,
	input  wire logic [1:0]   cfg_index,
	input  wire logic [63:0]  cfg_data
);
	localparam int NUM_D  = ssmc_pkg::SUFFIX_MAX + 1;
	localparam int PIDX_W = $clog2(ssmc_pkg::PATTERN_MAX);

	logic [4:0]  len_cfg_q;
	logic [63:0] pat_low_q;
	logic [63:0] pat_high_q;

	logic [ssmc_pkg::LEN_W-1:0]                  len;
	logic [ssmc_pkg::PATTERN_MAX-1:0][7:0]       pat;
	logic [ssmc_pkg::PATTERN_MAX-1:0][7:0]       rpat;

	logic [ssmc_pkg::WINDOW_LEN-1:0][7:0]        win;
	logic [ssmc_pkg::WINDOW_LEN-1:0]             win_valid;
	logic [ssmc_pkg::WINDOW_LEN-1:0][7:0]        feed_byte;
	logic [ssmc_pkg::WINDOW_LEN-1:0]             feed_valid;
	ssmc_pkg::cell_ctrl_t                        cell_ctrl;

	logic [ssmc_pkg::POSITION_BITS-1:0]          count_q;
	logic                                        pend_q;
	logic                                        eos_q;
	logic [NUM_D-1:0]                            done_q;
	logic [NUM_D-1:0]                            hit;
	logic [NUM_D-1:0]                            hit_eff;
	logic [NUM_D-1:0]                            avail;
	logic [NUM_D-1:0]                            sel_mask;
	logic [ssmc_pkg::DIST_W-1:0]                 sel_d;
	logic                                        more;
	logic                                        out_free;
	logic                                        emit;
	logic                                        step_done;
	logic                                        accept;
	logic                                        clear;

	ssmc_pkg::report_t                           rpt;
	ssmc_pkg::report_t                           report_q;
	logic                                        ovalid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_cfg_q  <= 5'd1;
			pat_low_q  <= '0;
			pat_high_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				ssmc_pkg::REG_PATTERN_LENGTH: len_cfg_q  <= cfg_data[4:0];
				ssmc_pkg::REG_PATTERN_LOW:    pat_low_q  <= cfg_data;
				ssmc_pkg::REG_PATTERN_HIGH:   pat_high_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_comb begin
		if (len_cfg_q == 5'd0) begin
			len = ssmc_pkg::LEN_W'(1);
		end else if (len_cfg_q > 5'(ssmc_pkg::PATTERN_MAX)) begin
			len = ssmc_pkg::LEN_W'(ssmc_pkg::PATTERN_MAX);
		end else begin
			len = ssmc_pkg::LEN_W'(len_cfg_q);
		end
		pat = {pat_high_q, pat_low_q};
		for (int j = 0; j < ssmc_pkg::PATTERN_MAX; j++) begin
			if (ssmc_pkg::LEN_W'(j) < len) begin
				rpat[j] = pat[PIDX_W'(len - ssmc_pkg::LEN_W'(1) - ssmc_pkg::LEN_W'(j))];
			end else begin
				rpat[j] = '0;
			end
		end
	end

	assign out_free  = !ovalid_q || report.ready;
	assign hit_eff   = hit & {1'b1, {ssmc_pkg::SUFFIX_MAX{eos_q}}};
	assign avail     = pend_q ? (hit_eff & ~done_q) : '0;

	always_comb begin
		sel_d = '0;
		for (int d = 0; d < NUM_D; d++) begin
			if (avail[d]) begin
				sel_d = ssmc_pkg::DIST_W'(d);
			end
		end
		sel_mask = NUM_D'(1) << sel_d;
	end

	assign more      = |(avail & ~sel_mask);
	assign emit      = (|avail) && out_free;
	assign step_done = pend_q && (!(|avail) || (emit && !more));
	assign stream.ready = !pend_q || step_done;
	assign accept    = stream.valid && stream.ready;
	assign clear     = step_done && eos_q;

	assign cell_ctrl = '{shift: accept, clear: clear};

	for (genvar k = 0; k < ssmc_pkg::WINDOW_LEN; k++) begin : g_cell
		if (k == 0) begin : g_head
			assign feed_byte[k]  = stream.data_byte;
			assign feed_valid[k] = 1'b1;
		end else begin : g_body
			assign feed_byte[k]  = clear ? 8'd0 : win[k-1];
			assign feed_valid[k] = clear ? 1'b0 : win_valid[k-1];
		end
		ssmc_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.ctrl      (cell_ctrl),
			.feed_byte (feed_byte[k]),
			.feed_valid(feed_valid[k]),
			.data_q    (win[k]),
			.valid_q   (win_valid[k])
		);
	end

	for (genvar d = 0; d < NUM_D; d++) begin : g_lane
		ssmc_lane u_lane (
			.win      (win[d +: ssmc_pkg::PATTERN_MAX]),
			.win_valid(win_valid[d +: ssmc_pkg::PATTERN_MAX]),
			.rpat     (rpat),
			.len      (len),
			.hit      (hit[d])
		);
	end

	ssmc_report u_report (
		.win      (win),
		.win_valid(win_valid),
		.len      (len),
		.sel_dist (sel_d),
		.count    (count_q),
		.last     (!more),
		.rpt      (rpt)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q  <= '0;
			pend_q   <= 1'b0;
			eos_q    <= 1'b0;
			done_q   <= '0;
			ovalid_q <= 1'b0;
		end else begin
			if (clear) begin
				count_q <= accept ? ssmc_pkg::POSITION_BITS'(1) : '0;
			end else if (accept) begin
				count_q <= count_q + ssmc_pkg::POSITION_BITS'(1);
			end
			if (accept) begin
				pend_q <= 1'b1;
				eos_q  <= stream.end_of_stream;
			end else if (step_done) begin
				pend_q <= 1'b0;
			end
			if (accept || step_done) begin
				done_q <= '0;
			end else if (emit) begin
				done_q <= done_q | sel_mask;
			end
			if (emit) begin
				ovalid_q <= 1'b1;
			end else if (report.ready) begin
				ovalid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			report_q <= rpt;
		end
	end

	assign report.valid          = ovalid_q;
	assign report.match_position = report_q.match_position;
	assign report.prefix_length  = report_q.prefix_length;
	assign report.prefix_context = report_q.prefix_context;
	assign report.suffix_length  = report_q.suffix_length;
	assign report.suffix_context = report_q.suffix_context;
	assign report.last_of_run    = report_q.last_of_run;

	// The window valid bits always form a run of ones from the newest cell.
	`SSMC_ASSERT_SAME(a_valid_run, 1'b1, ((win_valid + ssmc_pkg::WINDOW_LEN'(1)) & win_valid) == '0)
	// Reports already sent for a byte are always among its matches.
	`SSMC_ASSERT_SAME(a_done_subset, pend_q, (done_q & ~hit_eff) == '0)
	// Finishing an end-of-stream byte with no new byte leaves an empty window.
	`SSMC_ASSERT_NEXT(a_eos_clear, clear && !accept, win_valid == '0 && count_q == '0)
endmodule
`default_nettype wire
